@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl files
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, idle while reset is high
`define GBN_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check that also holds during reset
`define GBN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GBN_ASSERT(lbl, clk, rst, prop, msg)
`define GBN_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/gbn_pkg.sv @@
// shared types and constants of the greedy box nms unit
// no dependencies
`timescale 1ns / 1ps
package gbn_pkg;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int COORD_W   = 64;
  localparam int SCORE_W   = 16;
  localparam int THR_W     = 16;
  localparam logic [THR_W-1:0] THR_RESET = 16'd26214;
  localparam logic signed [17:0] ONE_PIXEL = 18'sd16;

  typedef struct packed {
    logic signed [15:0] box_x1;
    logic signed [15:0] box_y1;
    logic signed [15:0] box_x2;
    logic signed [15:0] box_y2;
    logic [15:0]        box_score;
    logic               last_box;
  } box_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]   kept_index;
    logic [SCORE_W-1:0] kept_score;
    logic               last_kept;
  } kept_out_t;

  // overlap test request and reply
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] tag;
  } pair_req_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] tag;
    logic             hit;
  } pair_res_t;
endpackage

@@ rtl/gbn_ram.sv @@
// generic one write port, one read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module gbn_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/gbn_iou.sv @@
// five stage pipelined overlap test: inter * 2^16 > thr * union, union > 0
// depends on gbn_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gbn_iou
  import gbn_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [THR_W-1:0]   thr,
  input  logic [COORD_W-1:0] coord_a,
  input  logic [COORD_W-1:0] coord_b,
  input  pair_req_t          req,
  output pair_res_t          res
);
  logic signed [15:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
  logic signed [15:0] ix1, iy1, ix2, iy2;
  logic signed [17:0] iw_raw, ih_raw;
  logic [4:0]         vld;
  logic [IDX_W-1:0]   tag1, tag2, tag3, tag4, tag5;
  logic               hit5;

  logic [16:0]        s1_iw, s1_ih;
  logic signed [17:0] s1_wa, s1_ha, s1_wb, s1_hb;
  logic [33:0]        s2_inter;
  logic signed [35:0] s2_area_a, s2_area_b;
  logic [33:0]        s3_inter;
  logic signed [37:0] s3_uni;
  logic [49:0]        s4_lhs;
  logic signed [54:0] s4_rhs;
  logic               s4_pos;

  assign ax1 = coord_a[15:0];
  assign ay1 = coord_a[31:16];
  assign ax2 = coord_a[47:32];
  assign ay2 = coord_a[63:48];
  assign bx1 = coord_b[15:0];
  assign by1 = coord_b[31:16];
  assign bx2 = coord_b[47:32];
  assign by2 = coord_b[63:48];

  // intersection corners
  assign ix1 = (ax1 > bx1) ? ax1 : bx1;
  assign iy1 = (ay1 > by1) ? ay1 : by1;
  assign ix2 = (ax2 < bx2) ? ax2 : bx2;
  assign iy2 = (ay2 < by2) ? ay2 : by2;
  assign iw_raw = 18'(ix2) - 18'(ix1) + ONE_PIXEL;
  assign ih_raw = 18'(iy2) - 18'(iy1) + ONE_PIXEL;

  // valid and tag pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], req.valid};
    end
    tag1 <= req.tag;
    tag2 <= tag1;
    tag3 <= tag2;
    tag4 <= tag3;
  end

  // datapath stages
  always_ff @(posedge clk) begin
    s1_iw <= iw_raw[17] ? 17'd0 : iw_raw[16:0];
    s1_ih <= ih_raw[17] ? 17'd0 : ih_raw[16:0];
    s1_wa <= 18'(ax2) - 18'(ax1) + ONE_PIXEL;
    s1_ha <= 18'(ay2) - 18'(ay1) + ONE_PIXEL;
    s1_wb <= 18'(bx2) - 18'(bx1) + ONE_PIXEL;
    s1_hb <= 18'(by2) - 18'(by1) + ONE_PIXEL;

    s2_inter  <= s1_iw * s1_ih;
    s2_area_a <= s1_wa * s1_ha;
    s2_area_b <= s1_wb * s1_hb;

    s3_inter <= s2_inter;
    s3_uni   <= 38'(s2_area_a) + 38'(s2_area_b) - $signed({4'b0, s2_inter});

    s4_lhs <= {s3_inter, 16'd0};
    s4_rhs <= $signed({1'b0, thr}) * s3_uni;
    s4_pos <= (s3_uni > 38'sd0);

    hit5 <= s4_pos && ($signed({6'b0, s4_lhs}) > 56'(s4_rhs));
    tag5 <= tag4;
  end

  // reply
  assign res = '{valid: vld[4], tag: tag5, hit: hit5};

  `GBN_ASSERT(a_iou_latency, clk, rst, res.valid |-> $past(req.valid, 5), "iou reply without request")
endmodule

@@ rtl/greedy_box_nms_unit.sv @@
// Greedy box non-maximum suppression. Boxes load one per start transfer; the
// box with last_box set closes the set and raises busy. The set is ranked by
// counting, for every box, the boxes that beat it, using the single score ram
// read port, then each ranked box that survives reads its coordinates once and
// streams all later boxes through the five stage overlap pipeline. Kept boxes
// appear on result with a one cycle result_valid strobe, in rank order; the
// receiver cannot stall, so it must take every strobe. busy falls with the
// final result (last_kept).
// depends on gbn_pkg, gbn_ram, gbn_iou and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module greedy_box_nms_unit
  import gbn_pkg::*;
#(
  parameter int MAX_BOXES = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  box_in_t      box,
  output logic         result_valid,
  output kept_out_t    result,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [THR_W-1:0] cfg_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_SORT_RD, S_SORT_SA, S_SORT_SCAN, S_SORT_WR,
    S_SUP_RANK, S_SUP_IDX, S_SUP_LOAD, S_SUP_SCAN, S_SUP_DRAIN, S_FINISH
  } state_t;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BOXES);

  state_t             state;
  logic [THR_W-1:0]   thr;
  logic [CNT_W-1:0]   box_count, a, b, rank_cnt;
  logic [SCORE_W-1:0] sa;
  logic               sv;
  logic [CNT_W-1:0]   sb;
  logic [63:0]        supp;
  logic [IDX_W-1:0]   ii;
  logic [COORD_W-1:0] a_coord;
  logic               pend_v;
  logic [IDX_W-1:0]   pend_idx;
  logic [SCORE_W-1:0] pend_score;
  logic               v1, v2;
  logic [IDX_W-1:0]   j2;
  logic [CNT_W-1:0]   inflight;

  logic               load_we, rank_we, issue;
  logic [IDX_W-1:0]   score_raddr;
  logic [SCORE_W-1:0] score_rdata;
  logic [COORD_W-1:0] coord_rdata;
  logic [IDX_W-1:0]   rank_rdata;
  logic               beats;
  pair_req_t          req;
  pair_res_t          res;

  assign cfg_ready = 1'b1;
  assign load_we   = start && !busy && (box_count < MAX_CNT);
  assign rank_we   = (state == S_SORT_WR);
  assign issue     = (state == S_SUP_SCAN);

  // score ram read address by phase
  always_comb begin
    unique case (state)
      S_SORT_RD:   score_raddr = a[IDX_W-1:0];
      S_SORT_SCAN: score_raddr = b[IDX_W-1:0];
      default:     score_raddr = rank_rdata;
    endcase
  end

  gbn_ram #(.WIDTH(COORD_W), .DEPTH(MAX_BOXES), .ADDR_W(IDX_W)) u_coord_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (box_count[IDX_W-1:0]),
    .wdata ({box.box_y2, box.box_x2, box.box_y1, box.box_x1}),
    .raddr (rank_rdata),
    .rdata (coord_rdata)
  );

  gbn_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_BOXES), .ADDR_W(IDX_W)) u_score_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (box_count[IDX_W-1:0]),
    .wdata (box.box_score),
    .raddr (score_raddr),
    .rdata (score_rdata)
  );

  gbn_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BOXES), .ADDR_W(IDX_W)) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (rank_cnt[IDX_W-1:0]),
    .wdata (a[IDX_W-1:0]),
    .raddr ((state == S_SUP_SCAN) ? b[IDX_W-1:0] : a[IDX_W-1:0]),
    .rdata (rank_rdata)
  );

  // overlap pipeline fed with later boxes of the ranking
  assign req.valid = v2;
  assign req.tag   = j2;

  gbn_iou u_iou (
    .clk     (clk),
    .rst     (rst),
    .thr     (thr),
    .coord_a (a_coord),
    .coord_b (coord_rdata),
    .req     (req),
    .res     (res)
  );

  // a stored score ranks ahead of box a
  assign beats = sv && ((score_rdata > sa) || ((score_rdata == sa) && (sb < a)));

  // rank ram to coord ram read chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
    end
    j2 <= rank_rdata;
  end

  // sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      busy         <= 1'b0;
      box_count    <= '0;
      thr          <= THR_RESET;
      supp         <= '0;
      pend_v       <= 1'b0;
      result_valid <= 1'b0;
      inflight     <= '0;
      sv           <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        thr <= cfg_data;
      end
      if (res.valid && res.hit) begin
        supp[res.tag] <= 1'b1;
      end
      inflight <= inflight + CNT_W'(issue) - CNT_W'(res.valid);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (load_we) begin
              box_count <= box_count + 1'b1;
            end
            if (box.last_box) begin
              busy  <= 1'b1;
              a     <= '0;
              state <= S_SORT_RD;
            end
          end
        end
        S_SORT_RD: begin
          state <= S_SORT_SA;
        end
        S_SORT_SA: begin
          sa       <= score_rdata;
          b        <= '0;
          rank_cnt <= '0;
          sv       <= 1'b0;
          state    <= S_SORT_SCAN;
        end
        S_SORT_SCAN: begin
          if (beats) begin
            rank_cnt <= rank_cnt + 1'b1;
          end
          sb <= b;
          if (b < box_count) begin
            sv <= 1'b1;
            b  <= b + 1'b1;
          end else begin
            sv <= 1'b0;
            if (!sv) begin
              state <= S_SORT_WR;
            end
          end
        end
        S_SORT_WR: begin
          if (a + 1'b1 == box_count) begin
            a     <= '0;
            state <= S_SUP_RANK;
          end else begin
            a     <= a + 1'b1;
            state <= S_SORT_RD;
          end
        end
        S_SUP_RANK: begin
          state <= S_SUP_IDX;
        end
        S_SUP_IDX: begin
          ii    <= rank_rdata;
          state <= S_SUP_LOAD;
        end
        S_SUP_LOAD: begin
          a_coord <= coord_rdata;
          if (supp[ii]) begin
            a     <= a + 1'b1;
            state <= (a + 1'b1 == box_count) ? S_FINISH : S_SUP_RANK;
          end else begin
            if (pend_v) begin
              result_valid      <= 1'b1;
              result.kept_index <= pend_idx;
              result.kept_score <= pend_score;
              result.last_kept  <= 1'b0;
            end
            pend_v     <= 1'b1;
            pend_idx   <= ii;
            pend_score <= score_rdata;
            b          <= a + 1'b1;
            state      <= (a + 1'b1 == box_count) ? S_FINISH : S_SUP_SCAN;
          end
        end
        S_SUP_SCAN: begin
          b <= b + 1'b1;
          if (b + 1'b1 == box_count) begin
            state <= S_SUP_DRAIN;
          end
        end
        S_SUP_DRAIN: begin
          if (inflight == '0 && !v1 && !v2) begin
            a     <= a + 1'b1;
            state <= (a + 1'b1 == box_count) ? S_FINISH : S_SUP_RANK;
          end
        end
        S_FINISH: begin
          result_valid      <= 1'b1;
          result.kept_index <= pend_idx;
          result.kept_score <= pend_score;
          result.last_kept  <= 1'b1;
          pend_v    <= 1'b0;
          supp      <= '0;
          box_count <= '0;
          busy      <= 1'b0;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `GBN_ASSERT(a_busy_low_idle, clk, rst, !busy |-> state == S_IDLE, "busy low outside idle")
  `GBN_ASSERT(a_idle_drained, clk, rst, (state == S_IDLE) |-> (inflight == '0), "pipe not drained")
  `GBN_ASSERT(a_mid_result_busy, clk, rst, (result_valid && !result.last_kept) |-> busy, "early result after set end")
  `GBN_ASSERT(a_count_limit, clk, rst, box_count <= MAX_CNT, "box count past limit")
endmodule

@@ sim/greedy_box_nms_unit_tb.sv @@
// testbench for the greedy box nms unit: box sets with random and directed content,
// kept boxes checked against an in-bench greedy suppression predictor
// depends on gbn_pkg and greedy_box_nms_unit
`timescale 1ns / 1ps
module greedy_box_nms_unit_tb;
  import gbn_pkg::*;

  localparam int MAX_SET = 64;
  localparam int STALL_LIMIT = 40000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  box_in_t box = '0;
  logic result_valid;
  kept_out_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [THR_W-1:0] cfg_data = '0;

  greedy_box_nms_unit #(.MAX_BOXES(MAX_SET)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .box(box),
    .result_valid(result_valid), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  box_in_t set_boxes[MAX_SET];
  int unsigned set_count = 0;
  logic [THR_W-1:0] iou_thr = THR_RESET;
  kept_out_t kept_expected[$];
  box_in_t box_pending[$];
  int unsigned idle_pct = 0;
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;

  // busy as seen at the rising edge, so the driver knows if the box was taken
  logic busy_at_edge = 1'b0;
  always @(posedge clk) busy_at_edge <= busy;

  // append a box to the driver queue
  task automatic queue_box(box_in_t b);
    box_pending.insert(box_pending.size(), b);
  endtask

  // +1 pixel overlap test, exact in 64-bit arithmetic
  function automatic bit overlap_exceeds(box_in_t a, box_in_t b, logic [15:0] thr);
    longint ix1, iy1, ix2, iy2, iw, ih, inter, area_a, area_b, uni;
    ix1 = (a.box_x1 > b.box_x1) ? a.box_x1 : b.box_x1;
    iy1 = (a.box_y1 > b.box_y1) ? a.box_y1 : b.box_y1;
    ix2 = (a.box_x2 < b.box_x2) ? a.box_x2 : b.box_x2;
    iy2 = (a.box_y2 < b.box_y2) ? a.box_y2 : b.box_y2;
    iw = ix2 - ix1 + 16;
    ih = iy2 - iy1 + 16;
    if (iw < 0) iw = 0;
    if (ih < 0) ih = 0;
    inter = iw * ih;
    area_a = (longint'(a.box_x2) - a.box_x1 + 16) * (longint'(a.box_y2) - a.box_y1 + 16);
    area_b = (longint'(b.box_x2) - b.box_x1 + 16) * (longint'(b.box_y2) - b.box_y1 + 16);
    uni = area_a + area_b - inter;
    if (uni <= 0) return 1'b0;
    return inter * 65536 > longint'(thr) * uni;
  endfunction

  // store one box; on the closing box rank the set and queue the kept boxes
  task automatic predict_kept(box_in_t b);
    int rank[MAX_SET];
    bit gone[MAX_SET];
    int pos, n, k, last_q;
    kept_out_t ko;
    if (set_count < MAX_SET) begin
      set_boxes[set_count] = b;
      set_count++;
    end
    if (!b.last_box) return;
    n = set_count;
    for (int a = 0; a < n; a++) begin
      pos = a;
      while (pos > 0 && set_boxes[rank[pos-1]].box_score < set_boxes[a].box_score) begin
        rank[pos] = rank[pos-1];
        pos--;
      end
      rank[pos] = a;
      gone[a] = 1'b0;
    end
    last_q = -1;
    for (int a = 0; a < n; a++) begin
      k = rank[a];
      if (gone[k]) continue;
      ko = '{kept_index: k[5:0], kept_score: set_boxes[k].box_score, last_kept: 1'b0};
      kept_expected.insert(kept_expected.size(), ko);
      last_q = kept_expected.size() - 1;
      for (int c = a + 1; c < n; c++)
        if (!gone[rank[c]] && overlap_exceeds(set_boxes[k], set_boxes[rank[c]], iou_thr))
          gone[rank[c]] = 1'b1;
    end
    kept_expected[last_q].last_kept = 1'b1;
    set_count = 0;
  endtask

  // driver: one box per transfer, random idle gaps
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy_at_edge) begin
      // previous box was taken at the last rising edge
      void'(box_pending.pop_front());
      if (box_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
        box <= box_pending[0];
      end else begin
        start <= 1'b0;
      end
    end else if (!start && box_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
      start <= 1'b1;
      box <= box_pending[0];
    end
  end

  // monitor: predict on accepted boxes, check every strobed result
  always @(posedge clk) begin
    kept_out_t want;
    bit seen;
    seen = 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        predict_kept(box);
        seen = 1'b1;
      end
      if (result_valid) begin
        seen = 1'b1;
        if (kept_expected.size() == 0) begin
          $display("%0t: unexpected result expected none actual %p", $time, result);
          errors++;
        end else begin
          want = kept_expected.pop_front();
          if (result !== want) begin
            $display("%0t: kept box mismatch expected %p actual %p", $time, want, result);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) iou_thr = cfg_data;
      quiet_cycles <= seen ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // a box near a centre, so that overlaps are common
  function automatic box_in_t near_box(int cx, int cy, bit last);
    box_in_t b;
    int w, h;
    w = $urandom_range(16, 400);
    h = $urandom_range(16, 400);
    b.box_x1 = 16'(cx + $signed($urandom_range(0, 120)) - 60);
    b.box_y1 = 16'(cy + $signed($urandom_range(0, 120)) - 60);
    b.box_x2 = 16'(b.box_x1 + w);
    b.box_y2 = 16'(b.box_y1 + h);
    b.box_score = ($urandom_range(3) == 0) ? 16'($urandom_range(3) * 100) : 16'($urandom);
    b.last_box = last;
    return b;
  endfunction

  task automatic queue_random_set(int n);
    box_in_t b;
    int cx, cy;
    cx = $urandom_range(0, 8000) - 4000;
    cy = $urandom_range(0, 8000) - 4000;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        b = box_in_t'(81'({$urandom, $urandom, $urandom}));
        b.last_box = (i == n - 1);
      end else begin
        b = near_box(cx, cy, i == n - 1);
      end
      queue_box(b);
    end
  endtask

  task automatic wait_drained();
    while (box_pending.size() > 0 || start || kept_expected.size() > 0 || busy)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int unsigned pct, int boxes);
    int n;
    idle_pct = pct;
    while (boxes > 0) begin
      n = ($urandom_range(7) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
      queue_random_set(n);
      boxes -= n;
    end
    wait_drained();
  endtask

  // stimulus
  initial begin
    box_in_t b;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, ties, degenerate and inverted boxes, single box set
    idle_pct = 37;
    queue_box('{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'hffff, 1'b0});
    queue_box('{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'hffff, 1'b0});
    queue_box('{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'h0000, 1'b0});
    queue_box('{16'sd0, 16'sd0, -16'sd16, -16'sd16, 16'h1234, 1'b0});
    queue_box('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h1234, 1'b0});
    queue_box('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h0001, 1'b1});
    queue_box('{16'sd5, 16'sd5, 16'sd100, 16'sd100, 16'h8000, 1'b1});
    queue_box('{16'sd0, 16'sd0, 16'sd160, 16'sd160, 16'h0100, 1'b0});
    queue_box('{16'sd8, 16'sd8, 16'sd168, 16'sd168, 16'h0200, 1'b0});
    queue_box('{16'sd500, 16'sd500, 16'sd600, 16'sd600, 16'h0200, 1'b1});
    wait_drained();
    // overflow: 66 boxes, two dropped, last flag still closes the set
    for (int i = 0; i < 66; i++) begin
      b = near_box(0, 0, i == 65);
      queue_box(b);
    end
    wait_drained();

    write_threshold(16'd0);
    run_phase(37, 55);
    write_threshold(16'($urandom));
    run_phase(37, 55);
    write_threshold(16'hffff);
    run_phase(85, 55);
    write_threshold(16'd32768);
    run_phase(0, 55);
    write_threshold(THR_RESET);
    run_phase(0, 55);

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
